@@ hdl/wtdr_pkg.sv @@
// Shared types and constants for the weighted-timespan difficulty retarget core.
// No dependencies; every other file imports this package.
package wtdr_pkg;

	localparam int TIME_W  = 64;
	localparam int WORK_W  = 64;
	localparam int CNT_W   = 7;
	localparam int TS_W    = 16;
	localparam int SPAN_W  = TS_W + 4;     // 10 * target spacing
	localparam int HALF_W  = CNT_W + TS_W; // ((len+1)/2) * spacing, len * spacing
	localparam int X_W     = HALF_W + 7;   // times 99
	localparam int SCL_W   = 24;           // 99% of the half-window span
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [TS_W-1:0] TS_RESET = 16'd120;
	localparam logic [3:0]      SPAN_MUL = 4'd10;
	localparam logic [6:0]      PCT_NUM  = 7'd99;

	// x / 100 as (x * RECIP) >> RECIP_SH, exact for x below 2^32
	localparam logic [30:0] RECIP    = 31'd1374389535;
	localparam int          RECIP_SH = 37;

	// register index, taken from paddr[2]
	localparam logic REG_TARGET_SPACING = 1'b0;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [CNT_W-1:0]  len;
		logic [WORK_W-1:0] diff;
		logic [63:0]       wsum;
	} job_t;

endpackage

@@ hdl/wtdr_if.sv @@
// Valid/ready channel interfaces: block records in, retarget results out.
// Depends on wtdr_pkg.
interface wtdr_rec_if;
	import wtdr_pkg::*;
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] block_time;
	logic [WORK_W-1:0] cumulative_work;
	logic              final_record;

	modport source (output valid, block_time, cumulative_work, final_record, input ready);
	modport sink   (input valid, block_time, cumulative_work, final_record, output ready);
endinterface

interface wtdr_lvl_if;
	logic        valid;
	logic        ready;
	logic [63:0] next_level;
	logic        product_overflow;

	modport source (output valid, next_level, product_overflow, input ready);
	modport sink   (input valid, next_level, product_overflow, output ready);
endinterface

@@ hdl/wtdr_front.sv @@
// Front end: takes records, tracks the running maximum and builds the weighted sum.
// Emits one job per window to the queue. Depends on wtdr_pkg and wtdr_rec_if.
module wtdr_front #(
	parameter int WINDOW_CAP = 60
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [wtdr_pkg::TS_W-1:0] target_spacing,
	wtdr_rec_if.sink                  rec,
	input  logic                      q_full,
	output logic                      push,
	output wtdr_pkg::job_t            push_job
);
	import wtdr_pkg::*;

	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(WINDOW_CAP);

	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] max_q;
	logic [WORK_W-1:0] first_q, latest_q;
	logic [63:0]       wsum_q;

	logic              vld_s1, last_s1, add_s1;
	logic [CNT_W-1:0]  idx_s1, len_s1;
	logic [TIME_W-1:0] span_s1;
	logic [WORK_W-1:0] diff_s1;

	logic              accept, drain, counted, is_first;
	logic [TIME_W-1:0] mx;
	logic [WORK_W-1:0] first_w, latest_w;
	logic [SPAN_W-1:0] cap, span_eff;
	logic [CNT_W+SPAN_W-1:0] prod;
	logic [63:0]       wsum_next;

	assign drain    = vld_s1 && (!last_s1 || !q_full);
	assign rec.ready = !vld_s1 || drain;
	assign accept   = rec.valid && rec.ready;
	assign counted  = cnt_q < CAP_C;
	assign is_first = cnt_q == '0;
	assign mx       = (rec.block_time > max_q) ? rec.block_time : max_q;
	assign first_w  = (counted && is_first) ? rec.cumulative_work : first_q;
	assign latest_w = counted ? rec.cumulative_work : latest_q;

	// stage 2: clamp the span and accumulate
	assign cap = SPAN_W'(SPAN_MUL) * SPAN_W'(target_spacing);
	always_comb begin
		if (span_s1 == '0) begin
			span_eff = SPAN_W'(1);
		end else if (span_s1 > TIME_W'(cap)) begin
			span_eff = cap;
		end else begin
			span_eff = span_s1[SPAN_W-1:0];
		end
	end
	assign prod      = (CNT_W+SPAN_W)'(idx_s1) * (CNT_W+SPAN_W)'(span_eff);
	assign wsum_next = add_s1 ? wsum_q + 64'(prod) : wsum_q;

	assign push          = drain && last_s1;
	assign push_job.len  = len_s1;
	assign push_job.diff = diff_s1;
	assign push_job.wsum = wsum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			max_q    <= '0;
			first_q  <= '0;
			latest_q <= '0;
			wsum_q   <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (accept) begin
				if (rec.final_record) begin
					cnt_q    <= '0;
					max_q    <= '0;
					first_q  <= '0;
					latest_q <= '0;
				end else if (counted) begin
					max_q    <= is_first ? rec.block_time : mx;
					first_q  <= first_w;
					latest_q <= rec.cumulative_work;
					cnt_q    <= cnt_q + CNT_W'(1);
				end
				vld_s1 <= 1'b1;
			end else if (drain) begin
				vld_s1 <= 1'b0;
			end
			if (drain) begin
				wsum_q <= last_s1 ? '0 : wsum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= rec.final_record;
			add_s1  <= counted && !is_first;
			idx_s1  <= cnt_q;
			span_s1 <= mx - max_q;
			len_s1  <= counted ? cnt_q + CNT_W'(1) : cnt_q;
			diff_s1 <= latest_w - first_w;
		end
	end

endmodule

@@ hdl/wtdr_queue.sv @@
// Short job queue between front and back ends.
// Depends on wtdr_pkg.
module wtdr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wtdr_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output wtdr_pkg::job_t head
);
	import wtdr_pkg::*;

	job_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full      = fill_q == (QPTR_W+1)'(QDEPTH);
	assign not_empty = fill_q != '0;
	assign head      = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= push_job;
		end
	end

endmodule

@@ hdl/wtdr_back.sv @@
// Back end: scaling, 64x24 product in two halves, overflow test and a bit-serial
// divider, then the output register. Depends on wtdr_pkg and wtdr_lvl_if.
module wtdr_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [wtdr_pkg::TS_W-1:0] target_spacing,
	input  logic                      q_valid,
	input  wtdr_pkg::job_t            q_head,
	output logic                      pop,
	wtdr_lvl_if.source                lvl
);
	import wtdr_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SCALE0 = 9'b000000010,
		ST_SCALE1 = 9'b000000100,
		ST_SCALE2 = 9'b000001000,
		ST_MUL0   = 9'b000010000,
		ST_MUL1   = 9'b000100000,
		ST_MUL2   = 9'b001000000,
		ST_DIV    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [HALF_W-1:0] half_q, floor_q;
	logic [X_W-1:0]    x_q;
	logic [SCL_W-1:0]  scaled_q;
	logic [63:0]       dvs_q, rem_q, quo_q;
	logic              ovf_q;
	logic [5:0]        step_q;
	logic [31+SCL_W:0] plo_q, phi_q;

	logic              out_vld_q, out_ovf_q;
	logic [63:0]       out_lvl_q;

	logic [CNT_W:0]        len_p1;
	logic [X_W+30:0]       recip_prod;
	logic [31:0]           mul_a;
	logic [31+SCL_W:0]     mul_p;
	logic [95:0]           full_prod;
	logic [64:0]           shifted;
	logic                  ge;
	logic                  out_free;

	assign len_p1     = {1'b0, job_q.len} + (CNT_W+1)'(1);
	assign recip_prod = (X_W+31)'(x_q) * (X_W+31)'(RECIP);
	assign mul_a      = (state_q == ST_MUL0) ? job_q.diff[31:0] : job_q.diff[63:32];
	assign mul_p      = (32+SCL_W)'(mul_a) * (32+SCL_W)'(scaled_q);
	assign full_prod  = {8'b0, phi_q, 32'b0} + {40'b0, plo_q};
	assign shifted    = {rem_q, quo_q[63]};
	assign ge         = shifted >= {1'b0, dvs_q};
	assign out_free   = !out_vld_q || lvl.ready;

	assign pop                  = (state_q == ST_IDLE) && q_valid;
	assign lvl.valid            = out_vld_q;
	assign lvl.next_level       = out_lvl_q;
	assign lvl.product_overflow = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (lvl.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) state_q <= ST_SCALE0;
				end
				ST_SCALE0: begin
					state_q <= (job_q.len <= CNT_W'(1)) ? ST_DONE : ST_SCALE1;
				end
				ST_SCALE1: state_q <= ST_SCALE2;
				ST_SCALE2: state_q <= ST_MUL0;
				ST_MUL0:   state_q <= ST_MUL1;
				ST_MUL1:   state_q <= ST_MUL2;
				ST_MUL2: begin
					state_q <= (full_prod[95:64] != '0) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= q_head;
			end
			ST_SCALE0: begin
				half_q  <= HALF_W'(len_p1[CNT_W:1]) * HALF_W'(target_spacing);
				floor_q <= (HALF_W'(job_q.len) * HALF_W'(target_spacing)) >> 1;
				quo_q   <= 64'd1;
				ovf_q   <= 1'b0;
			end
			ST_SCALE1: begin
				x_q <= X_W'(half_q) * X_W'(PCT_NUM);
			end
			ST_SCALE2: begin
				scaled_q <= recip_prod[RECIP_SH+SCL_W-1:RECIP_SH];
				if (job_q.wsum < 64'(floor_q)) begin
					dvs_q <= (floor_q == '0) ? 64'd1 : 64'(floor_q);
				end else begin
					dvs_q <= (job_q.wsum == '0) ? 64'd1 : job_q.wsum;
				end
			end
			ST_MUL0: plo_q <= mul_p;
			ST_MUL1: phi_q <= mul_p;
			ST_MUL2: begin
				if (full_prod[95:64] != '0) begin
					quo_q <= '0;
					ovf_q <= 1'b1;
				end else begin
					quo_q <= full_prod[63:0];
				end
				rem_q  <= '0;
				step_q <= 6'd63;
			end
			ST_DIV: begin
				rem_q  <= ge ? 64'(shifted - {1'b0, dvs_q}) : shifted[63:0];
				quo_q  <= {quo_q[62:0], ge};
				step_q <= step_q - 6'd1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_lvl_q <= quo_q;
					out_ovf_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/weighted_timespan_difficulty_retarget_core.sv @@
// Weighted-timespan difficulty retarget core: records in, one result per window out.
// Front accepts one record per cycle; a closing record stalls it while the queue is full.
// With the back end idle a closing record goes through the front stage, queue write, pop,
// 6 scaling/multiply steps, the 64-step divider and done into the result register.
// Short windows and overflowing ones skip ahead to done; the back end pops only in idle.
// Asynchronous active-low reset clears all window state; target_spacing resets to 120.
module weighted_timespan_difficulty_retarget_core #(
	parameter int WINDOW_CAP = 60
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wtdr_pkg::PADDR_W-1:0] paddr,
	input  logic [wtdr_pkg::PDATA_W-1:0] pwdata,
	output logic [wtdr_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	wtdr_rec_if.sink                     rec_in,
	wtdr_lvl_if.source                   lvl_out
);
	import wtdr_pkg::*;

	// configuration register; one word, selected by paddr[2]
	logic [TS_W-1:0] target_spacing_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TARGET_SPACING);
	assign prdata = (paddr[2] == REG_TARGET_SPACING) ? PDATA_W'(target_spacing_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_spacing_q <= TS_RESET;
		end else if (cfg_wr) begin
			target_spacing_q <= pwdata[TS_W-1:0];
		end
	end

	// front -> queue -> back
	job_t push_job, q_head;
	logic push, q_full, q_valid, pop;

	wtdr_front #(
		.WINDOW_CAP(WINDOW_CAP)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.target_spacing(target_spacing_q),
		.rec           (rec_in),
		.q_full        (q_full),
		.push          (push),
		.push_job      (push_job)
	);

	// decouples the transfer of records from the slow per-window arithmetic
	wtdr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_valid),
		.head     (q_head)
	);

	wtdr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.target_spacing(target_spacing_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.pop           (pop),
		.lvl           (lvl_out)
	);

endmodule
